// ===== src/hotp_pkg.sv =====
// ----------------------------------------------------------------------------
// HOTP package
// Shared types, constants and SHA-1 round helpers for the HOTP code generator.
// ----------------------------------------------------------------------------
package hotp_pkg;

	localparam int DIGITS = 6;
	localparam int unsigned MOD_VAL = 10 ** DIGITS;
	localparam logic [29:0] CODE_MOD = 30'(MOD_VAL);
	localparam logic [31:0] RECIP = 32'(64'd4294967296 / 64'(MOD_VAL));

	localparam int ROUNDS = 80;
	localparam int KEY_REGS = 8;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] hstate_t;
	typedef logic [15:0][31:0] wwin_t;

	localparam hstate_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam word_t IPAD_WORD = 32'h36363636;
	localparam word_t OPAD_WORD = 32'h5C5C5C5C;
	localparam word_t PAD_WORD = 32'h80000000;
	localparam word_t INNER_LEN = 32'h00000240;
	localparam word_t OUTER_LEN = 32'h000002A0;

	function automatic hstate_t sha1_round(hstate_t s, word_t w, logic [6:0] idx);
		word_t f;
		word_t k;
		word_t t;
		hstate_t r;
		if (idx < 7'd20) begin
			f = (s[1] & s[2]) | (~s[1] & s[3]);
			k = 32'h5A827999;
		end else if (idx < 7'd40) begin
			f = s[1] ^ s[2] ^ s[3];
			k = 32'h6ED9EBA1;
		end else if (idx < 7'd60) begin
			f = (s[1] & s[2]) | (s[1] & s[3]) | (s[2] & s[3]);
			k = 32'h8F1BBCDC;
		end else begin
			f = s[1] ^ s[2] ^ s[3];
			k = 32'hCA62C1D6;
		end
		t = {s[0][26:0], s[0][31:27]} + f + s[4] + k + w;
		r[0] = t;
		r[1] = s[0];
		r[2] = {s[1][1:0], s[1][31:2]};
		r[3] = s[2];
		r[4] = s[3];
		return r;
	endfunction

	function automatic wwin_t next_win(wwin_t w);
		wwin_t n;
		word_t x;
		x = w[13] ^ w[8] ^ w[2] ^ w[0];
		for (int j = 0; j < 15; j++) begin
			n[j] = w[j + 1];
		end
		n[15] = {x[30:0], x[31]};
		return n;
	endfunction

	function automatic hstate_t state_add(hstate_t a, hstate_t b);
		hstate_t r;
		for (int j = 0; j < 5; j++) begin
			r[j] = a[j] + b[j];
		end
		return r;
	endfunction

endpackage

// ===== src/hotp_hmac_sha1_code.sv =====
// ----------------------------------------------------------------------------
// HOTP HMAC-SHA1 code generator
// Turns a 64-bit moving counter into a decimal one-time password code.
// ----------------------------------------------------------------------------
// Usage:
// Key bytes are written through cfg_we/cfg_index/cfg_data, eight 64-bit
// registers, first key byte in the top bits, zero beyond the key length.
// After reset and after every key write the block hashes both padded key
// blocks, one round per cycle; in_ready stays low meanwhile.
// A counter transfer on in_valid/in_ready yields one code transfer on
// out_valid/out_ready. The path is a fully unrolled pipeline: 81 stages for
// the inner hash, 81 for the outer hash, then digest add, truncation and
// three stages of reduction by reciprocal multiply. Throughput is one code
// per cycle while no key hash runs and the receiver does not stall.
// All stages advance together; when the receiver stalls with a code held,
// the whole pipeline and in_ready hold, and nothing is lost or repeated.
// Reset clears all valid bits and the key registers.
// ----------------------------------------------------------------------------
module hotp_hmac_sha1_code (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] moving_counter,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] password_code
);
	import hotp_pkg::*;

	logic        en;
	logic        busy;
	hstate_t     ipad_mid;
	hstate_t     opad_mid;
	wwin_t       in_win;
	logic        inr_vld;
	hstate_t     inr_state;
	hstate_t     inr_dig;
	wwin_t       out_win;
	logic        otr_vld;
	hstate_t     otr_state;
	logic        mac_vld_s1;
	logic [159:0] mac_s1;
	logic        bin_vld_s2;
	logic [30:0] bin_s2;
	logic        prd_vld_s3;
	logic [30:0] bin_s3;
	logic [62:0] prd_s3;
	logic        qc_vld_s4;
	logic [30:0] bin_s4;
	logic [30:0] qc_s4;
	logic        out_valid_q;
	logic [19:0] code_q;
	hstate_t     mac_sum;
	logic [159:0] mac_shift;
	logic [59:0] qc_full;
	logic [30:0] rem;
	logic [30:0] rem_fix;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en && !busy;

	hotp_midstate u_mid (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.busy     (busy),
		.ipad_mid (ipad_mid),
		.opad_mid (opad_mid)
	);

	always_comb begin
		in_win     = '0;
		in_win[0]  = moving_counter[63:32];
		in_win[1]  = moving_counter[31:0];
		in_win[2]  = PAD_WORD;
		in_win[15] = INNER_LEN;
	end

	hotp_sha1_pipe u_inner (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid && in_ready),
		.in_state (ipad_mid),
		.in_win   (in_win),
		.out_vld  (inr_vld),
		.out_state(inr_state)
	);

	assign inr_dig = state_add(inr_state, ipad_mid);

	always_comb begin
		out_win = '0;
		for (int j = 0; j < 5; j++) begin
			out_win[j] = inr_dig[j];
		end
		out_win[5]  = PAD_WORD;
		out_win[15] = OUTER_LEN;
	end

	hotp_sha1_pipe u_outer (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (inr_vld),
		.in_state (opad_mid),
		.in_win   (out_win),
		.out_vld  (otr_vld),
		.out_state(otr_state)
	);

	assign mac_sum   = state_add(otr_state, opad_mid);
	assign mac_shift = mac_s1 << {mac_s1[3:0], 3'b000};
	assign qc_full   = prd_s3[62:32] * {1'b0, CODE_MOD[28:0] & 29'h1FFFFFFF} +
		(CODE_MOD[29] ? {prd_s3[62:32], 29'd0} : 60'd0);
	assign rem       = bin_s4 - qc_s4;
	assign rem_fix   = (rem >= {1'b0, CODE_MOD}) ? rem - {1'b0, CODE_MOD} : rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_vld_s1  <= 1'b0;
			bin_vld_s2  <= 1'b0;
			prd_vld_s3  <= 1'b0;
			qc_vld_s4   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			mac_vld_s1  <= otr_vld;
			bin_vld_s2  <= mac_vld_s1;
			prd_vld_s3  <= bin_vld_s2;
			qc_vld_s4   <= prd_vld_s3;
			out_valid_q <= qc_vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mac_s1 <= {mac_sum[0], mac_sum[1], mac_sum[2], mac_sum[3], mac_sum[4]};
			bin_s2 <= mac_shift[158:128];
			bin_s3 <= bin_s2;
			prd_s3 <= {32'd0, bin_s2} * {31'd0, RECIP};
			bin_s4 <= bin_s3;
			qc_s4  <= qc_full[30:0];
			code_q <= rem_fix[19:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign password_code = code_q;

endmodule

// ===== src/hotp_midstate.sv =====
// ----------------------------------------------------------------------------
// HOTP key midstate unit
// Holds the key registers and hashes the inner and outer padded key blocks
// one round per cycle after reset and after every key write.
// ----------------------------------------------------------------------------
module hotp_midstate (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [3:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	output logic             busy,
	output hotp_pkg::hstate_t ipad_mid,
	output hotp_pkg::hstate_t opad_mid
);
	import hotp_pkg::*;

	logic [KEY_REGS-1:0][63:0] key_q;
	logic                      start_q;
	logic                      busy_q;
	logic [6:0]                rnd_q;
	hstate_t                   ist_q;
	hstate_t                   ost_q;
	wwin_t                     iw_q;
	wwin_t                     ow_q;
	hstate_t                   imid_q;
	hstate_t                   omid_q;
	hstate_t                   ist_nx;
	hstate_t                   ost_nx;
	wwin_t                     kwin;

	always_comb begin
		for (int j = 0; j < KEY_REGS; j++) begin
			kwin[2 * j]     = key_q[j][63:32];
			kwin[2 * j + 1] = key_q[j][31:0];
		end
	end

	assign ist_nx = sha1_round(ist_q, iw_q[0], rnd_q);
	assign ost_nx = sha1_round(ost_q, ow_q[0], rnd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			start_q <= 1'b1;
			busy_q  <= 1'b0;
			rnd_q   <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index < 4'(KEY_REGS)) begin
					key_q[cfg_index[2:0]] <= cfg_data;
				end
				start_q <= 1'b1;
			end else begin
				start_q <= 1'b0;
			end
			if (start_q) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'(ROUNDS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_q) begin
			ist_q <= SHA1_IV;
			ost_q <= SHA1_IV;
			for (int j = 0; j < 16; j++) begin
				iw_q[j] <= kwin[j] ^ IPAD_WORD;
				ow_q[j] <= kwin[j] ^ OPAD_WORD;
			end
		end else if (busy_q) begin
			ist_q <= ist_nx;
			ost_q <= ost_nx;
			iw_q  <= next_win(iw_q);
			ow_q  <= next_win(ow_q);
			if (rnd_q == 7'(ROUNDS - 1)) begin
				imid_q <= state_add(ist_nx, SHA1_IV);
				omid_q <= state_add(ost_nx, SHA1_IV);
			end
		end
	end

	assign busy     = busy_q | start_q;
	assign ipad_mid = imid_q;
	assign opad_mid = omid_q;

endmodule

// ===== src/hotp_sha1_pipe.sv =====
// ----------------------------------------------------------------------------
// HOTP SHA-1 round pipeline
// One register stage per SHA-1 round; the message window travels with the
// working state. All stages advance together on the enable.
// ----------------------------------------------------------------------------
module hotp_sha1_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  hotp_pkg::hstate_t in_state,
	input  hotp_pkg::wwin_t   in_win,
	output logic              out_vld,
	output hotp_pkg::hstate_t out_state
);
	import hotp_pkg::*;

	logic    vld_s [0:ROUNDS];
	hstate_t st_s  [0:ROUNDS];
	wwin_t   win_s [0:ROUNDS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0]  <= in_state;
			win_s[0] <= in_win;
		end
	end

	for (genvar r = 0; r < ROUNDS; r++) begin : g_rnd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[r + 1] <= 1'b0;
			end else if (en) begin
				vld_s[r + 1] <= vld_s[r];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[r + 1] <= sha1_round(st_s[r], win_s[r][0], 7'(r));
			end
		end

		if (r < ROUNDS - 1) begin : g_win
			always_ff @(posedge clk) begin
				if (en) begin
					win_s[r + 1] <= next_win(win_s[r]);
				end
			end
		end
	end

	assign out_vld   = vld_s[ROUNDS];
	assign out_state = st_s[ROUNDS];

endmodule

// ===== src/hotp_chk.sv =====
// ----------------------------------------------------------------------------
// HOTP port checker
// Watches the top-level ports of the code generator and is bound to it.
// ----------------------------------------------------------------------------
module hotp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [19:0] password_code
);
	import hotp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(password_code))
		else $error("code transfer changed while stalled");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({10'd0, password_code} < CODE_MOD))
		else $error("code out of range");

	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input taken while key hash is stale");

	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

endmodule

bind hotp_hmac_sha1_code hotp_chk u_chk (.*);
